FILE: hdl/lbt_pkg.sv
// ----------------------------------------------------------------------------
// lbt_pkg: shared types and constants of the label backpatch table
// Field widths, codes, table entry layout and the controller/datapath links.
// ----------------------------------------------------------------------------
package lbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_W       = 32;
  localparam int ADDR_W      = 16;
  localparam int OFF_W       = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 56;

  typedef enum logic [1:0] {
    FUNC_REGISTER = 2'd0,
    FUNC_RESOLVE  = 2'd1,
    FUNC_CLEAR    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PATCH = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_END,
    S_CMP_RD,
    S_CMP_WR,
    S_RESP_OK,
    S_RESP_FULL,
    S_RESP_NONE
  } state_t;

  typedef struct packed {
    logic              wide;
    logic [ADDR_W-1:0] paddr;
    logic [ADDR_W-1:0] pos;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    reg_write;
    logic    clear;
    logic    scan_start;
    logic    mem_rd;
    logic    scan_step;
    logic    scan_finish;
    logic    cmp_step;
    logic    resp_load;
    status_t resp_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       match;
    logic       pend_valid;
    logic       out_free;
    logic       idx_zero;
    logic       cmp_done;
  } sts_t;

endpackage

FILE: hdl/label_backpatch_table_top.sv
// ----------------------------------------------------------------------------
// label_backpatch_table_top: pending forward-reference table
// Stores forward references and emits patch beats when labels resolve.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                    | tuser  | tlast
//  in_     | in  | label_key, position, patch_address, wide     | func   | -
//  out_    | out | out_address, offset_value, out_wide          | status | last
//
//  Register, clear and unknown items pass through dispatch and a response
//  state. A resolve over n live entries walks the table newest first, a read
//  and a compare per entry, and shows its last patch or the none-pending
//  answer when the walk ends (straight after dispatch on an empty table);
//  after a match, compaction holds the input while it reads and rewrites the
//  n entries. The table memory has one read and one write port (one read per
//  cycle). Output stalls hold the walk. Reset empties the table at once.
module label_backpatch_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // label_key[31:0], position[47:32], patch_address[63:48], wide_field[64]
  input  logic [lbt_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_address[15:0], offset_value[47:16], out_wide[48]
  output logic [lbt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  lbt_pkg::cmd_t cmd;
  lbt_pkg::sts_t sts;

  lbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/lbt_ctrl.sv
// ----------------------------------------------------------------------------
// lbt_ctrl: sequencing state machine of the label backpatch table
// Dispatches each item, walks the table on a resolve and compacts it after.
// ----------------------------------------------------------------------------
module lbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lbt_pkg::sts_t sts,
  output lbt_pkg::cmd_t cmd
);

  lbt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = lbt_pkg::S_DISPATCH;
      end
      lbt_pkg::S_DISPATCH: begin
        unique case (sts.func)
          lbt_pkg::FUNC_REGISTER:
            state_nxt = sts.full ? lbt_pkg::S_RESP_FULL : lbt_pkg::S_RESP_OK;
          lbt_pkg::FUNC_RESOLVE:
            state_nxt = sts.empty ? lbt_pkg::S_RESP_NONE : lbt_pkg::S_SCAN_RD;
          default: state_nxt = lbt_pkg::S_RESP_OK;
        endcase
      end
      lbt_pkg::S_SCAN_RD: state_nxt = lbt_pkg::S_SCAN_CMP;
      lbt_pkg::S_SCAN_CMP: begin
        if (!(sts.match && sts.pend_valid && !sts.out_free)) begin
          state_nxt = sts.idx_zero ? lbt_pkg::S_SCAN_END : lbt_pkg::S_SCAN_RD;
        end
      end
      lbt_pkg::S_SCAN_END: begin
        if (!sts.pend_valid) begin
          state_nxt = lbt_pkg::S_RESP_NONE;
        end else if (sts.out_free) begin
          state_nxt = lbt_pkg::S_CMP_RD;
        end
      end
      lbt_pkg::S_CMP_RD: state_nxt = lbt_pkg::S_CMP_WR;
      lbt_pkg::S_CMP_WR:
        state_nxt = sts.cmp_done ? lbt_pkg::S_IDLE : lbt_pkg::S_CMP_RD;
      lbt_pkg::S_RESP_OK,
      lbt_pkg::S_RESP_FULL,
      lbt_pkg::S_RESP_NONE: begin
        if (sts.out_free) state_nxt = lbt_pkg::S_IDLE;
      end
      default: state_nxt = lbt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.resp_code = lbt_pkg::ST_OK;
    in_tready     = 1'b0;
    unique case (state_r)
      lbt_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      lbt_pkg::S_DISPATCH: begin
        unique case (sts.func)
          lbt_pkg::FUNC_REGISTER: cmd.reg_write  = !sts.full;
          lbt_pkg::FUNC_RESOLVE:  cmd.scan_start = !sts.empty;
          lbt_pkg::FUNC_CLEAR:    cmd.clear      = 1'b1;
          default: ;
        endcase
      end
      lbt_pkg::S_SCAN_RD: cmd.mem_rd = 1'b1;
      lbt_pkg::S_SCAN_CMP:
        cmd.scan_step = !(sts.match && sts.pend_valid && !sts.out_free);
      lbt_pkg::S_SCAN_END: cmd.scan_finish = sts.pend_valid && sts.out_free;
      lbt_pkg::S_CMP_RD: cmd.mem_rd = 1'b1;
      lbt_pkg::S_CMP_WR: cmd.cmp_step = 1'b1;
      lbt_pkg::S_RESP_OK: begin
        cmd.resp_load = sts.out_free;
        cmd.resp_code = lbt_pkg::ST_OK;
      end
      lbt_pkg::S_RESP_FULL: begin
        cmd.resp_load = sts.out_free;
        cmd.resp_code = lbt_pkg::ST_FULL;
      end
      lbt_pkg::S_RESP_NONE: begin
        cmd.resp_load = sts.out_free;
        cmd.resp_code = lbt_pkg::ST_NONE;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/lbt_dpath.sv
// ----------------------------------------------------------------------------
// lbt_dpath: table storage, offset arithmetic and result register
// Entries are kept packed oldest first in indexes 0 .. count-1.
// ----------------------------------------------------------------------------
module lbt_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lbt_pkg::cmd_t                     cmd,
  output lbt_pkg::sts_t                     sts,
  input  logic [lbt_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lbt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int IDX_W = lbt_pkg::IDX_W;
  localparam int CNT_W = lbt_pkg::CNT_W;
  localparam int DEPTH = lbt_pkg::TABLE_DEPTH;
  localparam int AW    = lbt_pkg::ADDR_W;
  localparam int OW    = lbt_pkg::OFF_W;
  localparam int PAD_W = lbt_pkg::OUT_DATA_W - (AW + OW + 1);

  lbt_pkg::entry_t tbl_mem_r [DEPTH];
  lbt_pkg::entry_t rdata_r;
  lbt_pkg::entry_t item_r;
  logic [1:0]       func_r;

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] wptr_r;
  logic [DEPTH-1:0] hit_r;

  logic             pend_valid_r;
  logic [AW-1:0]    pend_addr_r;
  logic [OW-1:0]    pend_off_r;
  logic             pend_wide_r;

  logic             out_valid_r;
  lbt_pkg::status_t out_status_r;
  logic [AW-1:0]    out_addr_r;
  logic [OW-1:0]    out_off_r;
  logic             out_wide_r;
  logic             out_last_r;

  logic             out_free;
  logic             match;
  logic [AW:0]      diff;
  logic [OW-1:0]    offset;
  logic [CNT_W-1:0] last_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  lbt_pkg::entry_t  mem_wdata;

  assign out_free = !out_valid_r || out_tready;
  assign match    = (rdata_r.key == item_r.key);
  assign last_idx = count_r - CNT_W'(1);

  // label position minus instruction position, narrow patches wrap at 16 bits
  assign diff   = {1'b0, item_r.pos} - {1'b0, rdata_r.pos};
  assign offset = rdata_r.wide ? OW'(signed'(diff))
                               : OW'(signed'(diff[AW-1:0]));

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.full       = (count_r == CNT_W'(DEPTH));
    sts.empty      = (count_r == '0);
    sts.match      = match;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
    sts.idx_zero   = (idx_r == '0);
    sts.cmp_done   = (CNT_W'(idx_r) == last_idx);
  end

  // single write port: append on register, move survivors on compaction
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr_r;
    mem_wdata = rdata_r;
    if (cmd.reg_write) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[IDX_W-1:0];
      mem_wdata = item_r;
    end else if (cmd.cmp_step && !hit_r[idx_r]) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem_r[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rdata_r <= tbl_mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r     <= in_tuser;
      item_r.key   <= in_tdata[31:0];
      item_r.pos   <= in_tdata[47:32];
      item_r.paddr <= in_tdata[63:48];
      item_r.wide  <= in_tdata[64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      wptr_r       <= '0;
      hit_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.reg_write) count_r <= count_r + CNT_W'(1);
      if (cmd.clear) count_r <= '0;
      if (cmd.scan_start) begin
        idx_r        <= last_idx[IDX_W-1:0];
        hit_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (match) begin
          hit_r[idx_r] <= 1'b1;
          pend_valid_r <= 1'b1;
        end
        if (idx_r != '0) idx_r <= idx_r - IDX_W'(1);
      end
      if (cmd.scan_finish) begin
        pend_valid_r <= 1'b0;
        idx_r        <= '0;
        wptr_r       <= '0;
      end
      if (cmd.cmp_step) begin
        if (!hit_r[idx_r]) wptr_r <= wptr_r + IDX_W'(1);
        if (CNT_W'(idx_r) == last_idx) begin
          count_r <= CNT_W'(wptr_r) + CNT_W'(!hit_r[idx_r]);
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  // hold the newest match until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (cmd.scan_step && match) begin
      pend_addr_r <= rdata_r.paddr;
      pend_off_r  <= offset;
      pend_wide_r <= rdata_r.wide;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.scan_step && match && pend_valid_r) || cmd.scan_finish ||
                 cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.scan_step && match && pend_valid_r) || cmd.scan_finish) begin
      out_status_r <= lbt_pkg::ST_PATCH;
      out_addr_r   <= pend_addr_r;
      out_off_r    <= pend_off_r;
      out_wide_r   <= pend_wide_r;
      out_last_r   <= cmd.scan_finish;
    end else if (cmd.resp_load) begin
      out_status_r <= cmd.resp_code;
      out_addr_r   <= '0;
      out_off_r    <= '0;
      out_wide_r   <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_wide_r, out_off_r, out_addr_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/lbt_checker.sv
// ----------------------------------------------------------------------------
// lbt_checker: port-level checks of the label backpatch table
// Watches the result channel for stalls, reset and result encoding.
// ----------------------------------------------------------------------------
module lbt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lbt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lbt_pkg::ST_PATCH |-> out_tlast && out_tdata == '0)
    else $error("non-patch result not single, last and zero");

  a_narrow_sext: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lbt_pkg::ST_PATCH && !out_tdata[48] |->
      (out_tdata[47:32] == 16'h0000 && !out_tdata[31]) ||
      (out_tdata[47:32] == 16'hFFFF && out_tdata[31]))
    else $error("narrow patch offset not sign-extended");

endmodule

bind label_backpatch_table_top lbt_checker u_lbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the label backpatch table
// Streams register, resolve, clear and unknown items into the table and checks
// each result beat against a behavioral copy of the pending-reference table.
// The copy keeps live references newest first. Sender and receiver stall at
// random in the first two of three phases; the third runs without random stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int         DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [15:0] pos;
    logic [15:0] paddr;
    logic        wide;
  } ref_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] pos;
    logic [15:0] paddr;
    logic        wide;
  } live_ref_t;

  typedef struct packed {
    lbt_pkg::status_t status;
    logic [15:0]      addr;
    logic [31:0]      offset;
    logic             wide;
    logic             last;
  } patch_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lbt_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lbt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  logic                           out_tlast;

  ref_item_t     pending_items[$];
  ref_item_t     cur_item = '0;
  ref_item_t     next_item;
  live_ref_t     live_refs[$];
  patch_result_t expected_results[$];
  logic [31:0]   key_pool[4];

  int send_idle_pct = 16;
  int recv_idle_pct = 56;
  int items_accepted = 0;
  int beats_checked = 0;
  int patch_beats = 0;
  int full_answers = 0;
  int none_answers = 0;
  int mismatch_count = 0;

  label_backpatch_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Apply one accepted item to the table copy and queue the beats it causes.
  task automatic predict_results(input ref_item_t it);
    patch_result_t r;
    patch_result_t batch[$];
    live_ref_t     keep[$];
    logic [31:0]   diff;
    r.status = lbt_pkg::ST_OK;
    r.addr   = '0;
    r.offset = '0;
    r.wide   = 1'b0;
    r.last   = 1'b1;
    case (it.func)
      lbt_pkg::FUNC_REGISTER: begin
        if (live_refs.size() == lbt_pkg::TABLE_DEPTH) begin
          r.status = lbt_pkg::ST_FULL;
        end else begin
          live_refs.push_front('{key: it.key, pos: it.pos, paddr: it.paddr, wide: it.wide});
        end
        batch.push_back(r);
      end
      lbt_pkg::FUNC_CLEAR: begin
        live_refs.delete();
        batch.push_back(r);
      end
      lbt_pkg::FUNC_RESOLVE: begin
        foreach (live_refs[i]) begin
          if (live_refs[i].key == it.key) begin
            diff     = {16'h0, it.pos} - {16'h0, live_refs[i].pos};
            r.status = lbt_pkg::ST_PATCH;
            r.addr   = live_refs[i].paddr;
            r.wide   = live_refs[i].wide;
            r.offset = live_refs[i].wide ? diff : {{16{diff[15]}}, diff[15:0]};
            r.last   = 1'b0;
            batch.push_back(r);
          end else begin
            keep.push_back(live_refs[i]);
          end
        end
        live_refs = keep;
        if (batch.size() == 0) begin
          r.status = lbt_pkg::ST_NONE;
          r.last   = 1'b1;
          batch.push_back(r);
        end else begin
          batch[batch.size()-1].last = 1'b1;
        end
      end
      default: begin
        batch.push_back(r);
      end
    endcase
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  // Driver: hold the beat until accepted, then advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_results(cur_item);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          cur_item  <= next_item;
          in_tdata  <= {7'h0, next_item.wide, next_item.paddr, next_item.pos, next_item.key};
          in_tuser  <= next_item.func;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure and result checking.
  always @(posedge clk) begin
    patch_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (out_tuser == lbt_pkg::ST_PATCH) patch_beats++;
        if (out_tuser == lbt_pkg::ST_FULL) full_answers++;
        if (out_tuser == lbt_pkg::ST_NONE) none_answers++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat, status", out_tuser, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status) report_mismatch("status", out_tuser, want.status);
          if (out_tdata[15:0] != want.addr)
            report_mismatch("out_address", out_tdata[15:0], want.addr);
          if (out_tdata[47:16] != want.offset)
            report_mismatch("offset_value", out_tdata[47:16], want.offset);
          if (out_tdata[48] != want.wide) report_mismatch("out_wide", out_tdata[48], want.wide);
          if (out_tlast != want.last) report_mismatch("last", out_tlast, want.last);
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] func, input logic [31:0] key,
                          input logic [15:0] pos, input logic [15:0] paddr, input logic wide);
    pending_items.push_back('{func: func, key: key, pos: pos, paddr: paddr, wide: wide});
  endtask

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Mostly register/resolve traffic on a small key pool so resolves hit,
  // with clears, unknown funcs, stray keys and register bursts that can fill the table.
  task automatic add_random_items(input int count);
    int n;
    int roll;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        add_item(lbt_pkg::FUNC_REGISTER, key_pool[$urandom_range(0, 3)], pick_pos(),
                 16'($urandom), 1'($urandom));
        n++;
      end else if (roll < 73) begin
        add_item(lbt_pkg::FUNC_RESOLVE, key_pool[$urandom_range(0, 3)], pick_pos(),
                 16'($urandom), 1'($urandom));
        n++;
      end else if (roll < 80) begin
        add_item(lbt_pkg::FUNC_RESOLVE, $urandom, pick_pos(), 16'($urandom), 1'($urandom));
        n++;
      end else if (roll < 85) begin
        add_item(lbt_pkg::FUNC_CLEAR, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
        key_pool[$urandom_range(0, 3)] = $urandom;
        n++;
      end else if (roll < 89) begin
        add_item(FUNC_UNKNOWN, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
        n++;
      end else begin
        repeat (6) begin
          add_item(lbt_pkg::FUNC_REGISTER, key_pool[$urandom_range(0, 3)], pick_pos(),
                   16'($urandom), 1'($urandom));
        end
        n += 6;
      end
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, both widths, sign wrap, no match, unknown func.
    add_item(lbt_pkg::FUNC_REGISTER, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
    add_item(lbt_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_item(lbt_pkg::FUNC_RESOLVE, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0);
    add_item(lbt_pkg::FUNC_RESOLVE, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 1'b1);
    add_item(lbt_pkg::FUNC_RESOLVE, 32'h0000_0000, 16'h1234, 16'h0000, 1'b0);
    add_item(FUNC_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // Fill the table on one key, overflow it, then drain it in one resolve.
    for (int i = 0; i < lbt_pkg::TABLE_DEPTH; i++) begin
      add_item(lbt_pkg::FUNC_REGISTER, 32'hA5A5_5A5A, 16'(i * 16'h1111), 16'(16'hFFF0 + i),
               1'(i));
    end
    add_item(lbt_pkg::FUNC_REGISTER, 32'h1357_9BDF, 16'h4000, 16'h2000, 1'b1);
    add_item(lbt_pkg::FUNC_RESOLVE, 32'hA5A5_5A5A, 16'h8000, 16'h0000, 1'b0);
    add_item(lbt_pkg::FUNC_REGISTER, 32'h0F0F_0F0F, 16'h7FFF, 16'h0100, 1'b0);
    add_item(lbt_pkg::FUNC_CLEAR, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
    add_item(lbt_pkg::FUNC_RESOLVE, 32'h0F0F_0F0F, 16'h0000, 16'h0000, 1'b0);
    add_random_items(51);
    wait_idle();

    send_idle_pct = 56;
    recv_idle_pct = 16;
    add_random_items(51);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_items(51);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items; checked %0d result beats (%0d patches, %0d full, %0d none).",
             items_accepted, beats_checked, patch_beats, full_answers, none_answers);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             mismatch_count, expected_results.size());
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
